>>> hdl/led_breathing_and_hue_sweep_core_assert.svh
// Assertion macros for the checker of the breathing and hue sweep core.
// Each macro expects clk and rst_n in scope.
`ifndef LED_BREATHING_AND_HUE_SWEEP_CORE_ASSERT_SVH
`define LED_BREATHING_AND_HUE_SWEEP_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define LBHS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed in %m");

// Next-cycle implication, checked out of reset.
`define LBHS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed in %m");

`endif

>>> hdl/lbhs_pkg.sv
package lbhs_pkg;

    localparam int OP_W       = 2;
    localparam int TIME_W     = 32;
    localparam int COLOUR_W   = 3;
    localparam int CHAN_W     = 8;
    localparam int INTERVAL_W = 10;
    localparam int PERIOD_W   = 13;
    localparam int PHASE_W    = 16;
    localparam int COS_W      = 17;

    localparam int COS_ENTRIES_DEFAULT = 256;

    // Long division of {now_ms, 16 zero bits} by the period, one bit a cycle.
    localparam int DIV_STEPS = TIME_W + PHASE_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 10'd20;
    localparam logic [PERIOD_W-1:0]   COOL_PERIOD_MS = 13'd8000;
    localparam logic [PERIOD_W-1:0]   WARM_PERIOD_MS = 13'd7000;

    localparam logic [OP_W-1:0] OP_SOLID = 2'd0;
    localparam logic [OP_W-1:0] OP_COOL  = 2'd1;
    localparam logic [OP_W-1:0] OP_WARM  = 2'd2;

    localparam logic [COLOUR_W-1:0] COL_OFF   = 3'd0;
    localparam logic [COLOUR_W-1:0] COL_RED   = 3'd1;
    localparam logic [COLOUR_W-1:0] COL_GREEN = 3'd2;
    localparam logic [COLOUR_W-1:0] COL_BLUE  = 3'd3;
    localparam logic [COLOUR_W-1:0] COL_AMBER = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_LOOKUP,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic start;
        logic warm;
    } div_ctrl_t;

    typedef struct packed {
        logic                 done;
        logic [PHASE_W-1:0]   phase;
    } div_stat_t;

    localparam logic [63:0] ONE_Q30    = 64'd1073741824;
    localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

    // Cosine over a quarter turn; t in Q0.32 turns (t <= 2^30), result Q30.
    function automatic logic [63:0] cos_quarter(input logic [63:0] t);
        logic [63:0] th;
        logic [63:0] u;
        logic [63:0] r;
        logic [63:0] s;
        th = (t * TWO_PI_Q30) >> 32;
        u  = (th * th) >> 30;
        r  = ONE_Q30;
        s  = ((u * r) >> 30) / 64'd132;
        r  = (s >= ONE_Q30) ? 64'd0 : ONE_Q30 - s;
        s  = ((u * r) >> 30) / 64'd90;
        r  = (s >= ONE_Q30) ? 64'd0 : ONE_Q30 - s;
        s  = ((u * r) >> 30) / 64'd56;
        r  = (s >= ONE_Q30) ? 64'd0 : ONE_Q30 - s;
        s  = ((u * r) >> 30) / 64'd30;
        r  = (s >= ONE_Q30) ? 64'd0 : ONE_Q30 - s;
        s  = ((u * r) >> 30) / 64'd12;
        r  = (s >= ONE_Q30) ? 64'd0 : ONE_Q30 - s;
        s  = ((u * r) >> 30) / 64'd2;
        r  = (s >= ONE_Q30) ? 64'd0 : ONE_Q30 - s;
        return r;
    endfunction

    // Table entry in Q1.15 for an angle in Q0.32 turns.
    function automatic logic signed [COS_W-1:0] cos_entry(input logic [63:0] a);
        logic [1:0]  quad;
        logic [63:0] rem;
        logic [63:0] c;
        logic [63:0] q;
        quad = a[31:30];
        rem  = {34'd0, a[29:0]};
        if (quad == 2'd0 || quad == 2'd2) begin
            c = cos_quarter(rem);
        end else begin
            c = cos_quarter(ONE_Q30 - rem);
        end
        q = (c + 64'd16384) >> 15;
        if (quad == 2'd1 || quad == 2'd2) begin
            q = 64'd0 - q;
        end
        return COS_W'(q);
    endfunction

endpackage

>>> hdl/lbhs_req_if.sv
interface lbhs_req_if;
    logic                            valid;
    logic                            ready;
    logic [lbhs_pkg::OP_W-1:0]       op;
    logic [lbhs_pkg::TIME_W-1:0]     now_ms;
    logic [lbhs_pkg::COLOUR_W-1:0]   solid_colour;

    modport source (output valid, op, now_ms, solid_colour, input ready);
    modport sink   (input valid, op, now_ms, solid_colour, output ready);
endinterface

>>> hdl/lbhs_rgb_if.sv
interface lbhs_rgb_if;
    logic                          valid;
    logic                          ready;
    logic [lbhs_pkg::CHAN_W-1:0]   red;
    logic [lbhs_pkg::CHAN_W-1:0]   green;
    logic [lbhs_pkg::CHAN_W-1:0]   blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

>>> hdl/lbhs_cfg_if.sv
interface lbhs_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [lbhs_pkg::INTERVAL_W-1:0]   frame_interval_ms;

    modport source (output valid, frame_interval_ms, input ready);
    modport sink   (input valid, frame_interval_ms, output ready);
endinterface

>>> hdl/lbhs_divider.sv
module lbhs_divider (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lbhs_pkg::div_ctrl_t           ctrl,
    input  logic [lbhs_pkg::TIME_W-1:0]   now_ms,
    output lbhs_pkg::div_stat_t           stat
);
    import lbhs_pkg::*;

    localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(DIV_STEPS - 1);

    logic                   busy_reg, busy_next;
    logic [DIV_CNT_W-1:0]   count_reg, count_next;
    logic [TIME_W-1:0]      dividend_reg, dividend_next;
    logic [PERIOD_W-1:0]    rem_reg, rem_next;
    logic [PERIOD_W-1:0]    period_reg, period_next;
    logic [PHASE_W-1:0]     quot_reg, quot_next;

    logic [PERIOD_W:0]      trial;
    logic                   fits;
    logic                   last;

    // One restoring step: bring down the next dividend bit, subtract if it fits.
    assign trial = {rem_reg, dividend_reg[TIME_W-1]};
    assign fits  = trial >= {1'b0, period_reg};
    assign last  = busy_reg && (count_reg == LAST_STEP);

    always_comb begin
        busy_next     = busy_reg;
        count_next    = count_reg;
        dividend_next = dividend_reg;
        rem_next      = rem_reg;
        period_next   = period_reg;
        quot_next     = quot_reg;
        if (ctrl.start) begin
            busy_next     = 1'b1;
            count_next    = '0;
            dividend_next = now_ms;
            rem_next      = '0;
            period_next   = ctrl.warm ? WARM_PERIOD_MS : COOL_PERIOD_MS;
        end else if (busy_reg) begin
            count_next    = count_reg + 1'b1;
            dividend_next = {dividend_reg[TIME_W-2:0], 1'b0};
            rem_next      = fits ? PERIOD_W'(trial - {1'b0, period_reg}) : trial[PERIOD_W-1:0];
            quot_next     = {quot_reg[PHASE_W-2:0], fits};
            if (last) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            busy_reg  <= busy_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk) begin
        dividend_reg <= dividend_next;
        rem_reg      <= rem_next;
        period_reg   <= period_next;
        quot_reg     <= quot_next;
    end

    assign stat.done  = last;
    assign stat.phase = quot_reg;

endmodule

>>> hdl/lbhs_cos_rom.sv
module lbhs_cos_rom #(
    parameter int ENTRIES = lbhs_pkg::COS_ENTRIES_DEFAULT
) (
    input  logic                                 clk,
    input  logic [$clog2(ENTRIES)-1:0]           addr,
    output logic signed [lbhs_pkg::COS_W-1:0]    data
);
    import lbhs_pkg::*;

    logic signed [COS_W-1:0] rom [ENTRIES];
    logic signed [COS_W-1:0] data_reg;

    // Entry k holds cos(2*pi*k/ENTRIES), fixed at elaboration.
    for (genvar k = 0; k < ENTRIES; k++) begin : g_entry
        localparam logic [63:0] ANGLE = (64'(k) << 32) / 64'(ENTRIES);
        localparam logic signed [COS_W-1:0] VALUE = cos_entry(ANGLE);
        assign rom[k] = VALUE;
    end

    always_ff @(posedge clk) begin
        data_reg <= rom[addr];
    end

    assign data = data_reg;

endmodule

>>> hdl/led_breathing_and_hue_sweep_core.sv
// Sequence: a solid beat goes from the mode check straight to the output slot; an
//   animated beat runs the frame guard check, 48 bit-serial division steps, the index
//   and table read, then the mix. Flow: one request at a time; ready returns once the
//   result is loaded into the output slot or the beat is dropped, and stays low while
//   the output is stalled.
// Reset: rst_n asynchronous, active low; interval returns to 20 ms, both last frame
//   times to 0, output slot empty. No clearing pass.
module led_breathing_and_hue_sweep_core #(
    parameter int COS_TABLE_ENTRIES = lbhs_pkg::COS_ENTRIES_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    lbhs_req_if.sink       req,
    lbhs_rgb_if.source     rgb,
    lbhs_cfg_if.sink       cfg
);
    import lbhs_pkg::*;

    localparam int IDX_W  = $clog2(COS_TABLE_ENTRIES);
    localparam int PROD_W = PHASE_W + IDX_W + 1;

    // Control and configuration
    state_t                 state_reg, state_next;
    logic [INTERVAL_W-1:0]  interval_reg;
    logic [TIME_W-1:0]      cool_last_reg;
    logic [TIME_W-1:0]      warm_last_reg;

    // Latched request beat
    logic [OP_W-1:0]        op_reg;
    logic [TIME_W-1:0]      now_reg;
    logic [COLOUR_W-1:0]    colour_reg;

    // Output slot
    logic                   out_valid_reg, out_valid_next;
    logic [CHAN_W-1:0]      red_reg, green_reg, blue_reg;

    logic                   req_fire;
    logic                   animated;
    logic [TIME_W-1:0]      last_sel;
    logic [TIME_W-1:0]      elapsed;
    logic                   too_soon;
    logic                   out_free;
    logic                   frame_go;
    logic                   load_out;

    div_ctrl_t              div_ctrl;
    div_stat_t              div_stat;

    logic [PROD_W-1:0]          idx_prod;
    logic [IDX_W-1:0]           cos_idx;
    logic signed [COS_W-1:0]    cos_val;

    logic [COS_W-1:0]       x;
    logic [COS_W-1:0]       x_inv;
    logic [21:0]            r_prod;
    logic [23:0]            g_prod;
    logic [23:0]            b_prod;
    logic [PHASE_W+1:0]     warm_f;
    logic [24:0]            w_prod;
    logic [CHAN_W-1:0]      red_mix, green_mix, blue_mix;

    assign req_fire = req.valid && req.ready;
    assign out_free = !out_valid_reg || rgb.ready;

    // Frame guard: wrapping 32-bit elapsed time against the interval.
    assign animated = (op_reg == OP_COOL) || (op_reg == OP_WARM);
    assign last_sel = (op_reg == OP_WARM) ? warm_last_reg : cool_last_reg;
    assign elapsed  = now_reg - last_sel;
    assign too_soon = elapsed < TIME_W'(interval_reg);

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (req_fire) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (op_reg == OP_SOLID) begin
                    state_next = ST_EMIT;
                end else if (animated && !too_soon) begin
                    state_next = ST_DIV;
                end else begin
                    // Drop unknown modes and frames that come too soon.
                    state_next = ST_IDLE;
                end
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb begin
        req.ready = 1'b0;
        frame_go  = 1'b0;
        load_out  = 1'b0;
        unique case (state_reg)
            ST_IDLE:   req.ready = 1'b1;
            ST_CHECK:  frame_go  = animated && !too_soon;
            ST_DIV:    ;
            ST_LOOKUP: ;
            ST_EMIT:   load_out  = out_free;
            default:   ;
        endcase
    end

    assign div_ctrl.start = frame_go;
    assign div_ctrl.warm  = (op_reg == OP_WARM);

    lbhs_divider u_divider (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (div_ctrl),
        .now_ms (now_reg),
        .stat   (div_stat)
    );

    // Table index is floor(phase * N / 65536); the phase is settled after the last step.
    assign idx_prod = PROD_W'(div_stat.phase) * PROD_W'(COS_TABLE_ENTRIES);
    assign cos_idx  = idx_prod[PHASE_W +: IDX_W];

    lbhs_cos_rom #(
        .ENTRIES (COS_TABLE_ENTRIES)
    ) u_cos_rom (
        .clk  (clk),
        .addr (cos_idx),
        .data (cos_val)
    );

    // Cool breath: x = 0.5 - cos/2 in Q0.16, always within 0 .. 1.0.
    assign x      = COS_W'(17'h08000 - COS_W'(cos_val));
    assign x_inv  = COS_W'(17'h10000 - x);
    assign r_prod = 22'(x_inv) * 22'd30;
    assign g_prod = 24'd6553600 + 24'(x) * 24'd55;
    assign b_prod = 24'd16711680 - 24'(x) * 24'd155;

    // Warm sweep: f = 0.25 + phase/2 in Q0.17, green is 204 * f.
    assign warm_f = (PHASE_W+2)'(32768) + (PHASE_W+2)'(div_stat.phase);
    assign w_prod = 25'(warm_f) * 25'd204;

    always_comb begin
        red_mix   = '0;
        green_mix = '0;
        blue_mix  = '0;
        if (op_reg == OP_COOL) begin
            red_mix   = CHAN_W'(r_prod[21:16]);
            green_mix = g_prod[23:16];
            blue_mix  = b_prod[23:16];
        end else if (op_reg == OP_WARM) begin
            red_mix   = 8'd204;
            green_mix = w_prod[24:17];
        end else begin
            unique case (colour_reg)
                COL_RED:   red_mix = 8'd255;
                COL_GREEN: green_mix = 8'd255;
                COL_BLUE:  blue_mix = 8'd255;
                COL_AMBER: begin
                    red_mix   = 8'd255;
                    green_mix = 8'd100;
                end
                default:   ;
            endcase
        end
    end

    // Hold a result until taken; a new one may replace it in the cycle it leaves.
    assign out_valid_next = load_out || (out_valid_reg && !rgb.ready);

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            interval_reg  <= INTERVAL_RESET;
            cool_last_reg <= '0;
            warm_last_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready) begin
                interval_reg <= cfg.frame_interval_ms;
            end
            // Advance the frame mark of the mode that passed the guard.
            if (frame_go && op_reg == OP_COOL) begin
                cool_last_reg <= now_reg;
            end
            if (frame_go && op_reg == OP_WARM) begin
                warm_last_reg <= now_reg;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (req_fire) begin
            op_reg     <= req.op;
            now_reg    <= req.now_ms;
            colour_reg <= req.solid_colour;
        end
        if (load_out) begin
            red_reg   <= red_mix;
            green_reg <= green_mix;
            blue_reg  <= blue_mix;
        end
    end

    assign rgb.valid = out_valid_reg;
    assign rgb.red   = red_reg;
    assign rgb.green = green_reg;
    assign rgb.blue  = blue_reg;

endmodule

>>> hdl/lbhs_checker.sv
`include "led_breathing_and_hue_sweep_core_assert.svh"

module lbhs_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             req_valid,
    input logic                             req_ready,
    input logic                             rgb_valid,
    input logic                             rgb_ready,
    input logic [lbhs_pkg::CHAN_W-1:0]      rgb_red,
    input logic [lbhs_pkg::CHAN_W-1:0]      rgb_green,
    input logic [lbhs_pkg::CHAN_W-1:0]      rgb_blue
);

    // Hold a stalled beat.
    `LBHS_ASSERT_NEXT(a_rgb_hold, rgb_valid && !rgb_ready, rgb_valid)
    `LBHS_ASSERT_NEXT(a_rgb_stable, rgb_valid && !rgb_ready, $stable(rgb_red) && $stable(rgb_green) && $stable(rgb_blue))

    // One request in flight: ready drops after every accepted beat.
    `LBHS_ASSERT_NEXT(a_req_single, req_valid && req_ready, !req_ready)

    // Only the warm sweep gives red 204, and then blue is off and green in its range.
    `LBHS_ASSERT_IMPL(a_warm_shape, rgb_valid && rgb_red == 8'd204, rgb_blue == 8'd0 && rgb_green >= 8'd51 && rgb_green <= 8'd152)

endmodule

bind led_breathing_and_hue_sweep_core lbhs_checker u_lbhs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rgb_valid (rgb.valid),
    .rgb_ready (rgb.ready),
    .rgb_red   (rgb.red),
    .rgb_green (rgb.green),
    .rgb_blue  (rgb.blue)
);
